/* rtl/core/u16u8_pkg.sv */
`timescale 1ns / 1ps

package u16u8_pkg;

  // queue between the byte pairing front and the utf-8 serializer
  localparam int QUEUE_DEPTH = 4;

  // code point width: widest merged surrogate pair is 0x20FFFF
  localparam int CP_W = 22;

  localparam logic [15:0]     SURR_LO   = 16'hD800;
  localparam logic [15:0]     SURR_HI   = 16'hDFFF;
  localparam logic [CP_W-1:0] SUPP_BASE = 22'h010000;
  localparam logic [CP_W-1:0] CP1_MAX   = 22'h00007F;
  localparam logic [CP_W-1:0] CP2_MAX   = 22'h0007FF;
  localparam logic [CP_W-1:0] CP3_MAX   = 22'h00FFFF;
  localparam logic [7:0]      LEAD2     = 8'hC0;
  localparam logic [7:0]      LEAD3     = 8'hE0;
  localparam logic [7:0]      LEAD4     = 8'hF0;
  localparam logic [7:0]      CONT      = 8'h80;
  localparam logic [5:0]      SIX_MASK  = 6'h3F;

  // one request for the serializer: an optional code point, then an optional terminator
  typedef struct packed {
    logic            cp_valid;
    logic [CP_W-1:0] cp;
    logic            term;
    logic            odd;
  } job_t;

  // continuation byte from six payload bits
  function automatic logic [7:0] cont_byte(input logic [5:0] bits6);
    cont_byte = CONT | {2'b00, bits6 & SIX_MASK};
  endfunction

endpackage

/* rtl/core/u16u8_front.sv */
`timescale 1ns / 1ps

module u16u8_front
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] in_byte,
  input  logic       in_string_last,
  output logic       push,
  output job_t       job
);

  logic [7:0]  held_low_r, held_low_nxt;
  logic        low_valid_r, low_valid_nxt;
  logic [10:0] pend_r, pend_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic [15:0] unit;
  logic [15:0] unit_off;
  logic        is_surr;

  assign unit     = {in_byte, held_low_r};
  assign unit_off = unit - SURR_LO;
  assign is_surr  = (unit >= SURR_LO) && (unit <= SURR_HI);

  // pair bytes into units, park surrogates, build the serializer request
  always_comb begin
    held_low_nxt   = held_low_r;
    low_valid_nxt  = low_valid_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    job            = '0;
    if (!low_valid_r) begin
      held_low_nxt  = in_byte;
      low_valid_nxt = 1'b1;
    end else begin
      low_valid_nxt = 1'b0;
      held_low_nxt  = '0;
      if (pend_valid_r) begin
        job.cp_valid   = 1'b1;
        job.cp         = CP_W'({pend_r, 10'd0}) + SUPP_BASE + CP_W'(unit[9:0]);
        pend_valid_nxt = 1'b0;
        pend_nxt       = '0;
      end else if (is_surr && !in_string_last) begin
        pend_nxt       = unit_off[10:0];
        pend_valid_nxt = 1'b1;
      end else begin
        job.cp_valid = 1'b1;
        job.cp       = CP_W'(unit);
      end
    end
    // string end: flush a parked surrogate, close with terminator
    if (in_string_last) begin
      job.odd  = low_valid_nxt;
      job.term = 1'b1;
      if (pend_valid_nxt) begin
        job.cp_valid = 1'b1;
        job.cp       = CP_W'(SURR_LO) + CP_W'(pend_nxt);
      end
      held_low_nxt   = '0;
      low_valid_nxt  = 1'b0;
      pend_nxt       = '0;
      pend_valid_nxt = 1'b0;
    end
  end

  assign push = acc && (job.cp_valid || job.term);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_low_r   <= '0;
      low_valid_r  <= 1'b0;
      pend_r       <= '0;
      pend_valid_r <= 1'b0;
    end else if (acc) begin
      held_low_r   <= held_low_nxt;
      low_valid_r  <= low_valid_nxt;
      pend_r       <= pend_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

endmodule

/* rtl/core/u16u8_fifo.sv */
`timescale 1ns / 1ps

module u16u8_fifo
  import u16u8_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/u16u8_back.sv */
`timescale 1ns / 1ps

module u16u8_back
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_is_terminator,
  output logic       out_odd_dropped
);

  logic       cur_valid_r;
  logic [7:0] bytes_r [4];
  logic [2:0] rem_r;
  logic       term_r;
  logic       odd_r;

  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       run_last_r, is_term_r, odd_out_r;

  logic       out_free, emit, done;
  logic [7:0] e_byte;
  logic       e_last, e_term, e_odd;
  logic [7:0] enc [4];
  logic [2:0] enc_n;
  logic [CP_W-1:0] cp;

  assign out_free = !out_valid_r || out_ready;
  assign emit     = out_free && cur_valid_r;

  // next byte of the current request
  always_comb begin
    if (rem_r != '0) begin
      e_byte = bytes_r[0];
      e_term = 1'b0;
      e_odd  = 1'b0;
      e_last = (rem_r == 3'd1) && !term_r;
    end else begin
      e_byte = '0;
      e_term = 1'b1;
      e_odd  = odd_r;
      e_last = 1'b1;
    end
  end

  assign done = emit && e_last;
  assign pop  = head_valid && (!cur_valid_r || done);

  // utf-8 encoding of the request at the queue head
  assign cp = head_job.cp;
  always_comb begin
    enc[0] = '0;
    enc[1] = '0;
    enc[2] = '0;
    enc[3] = '0;
    if (cp <= CP1_MAX) begin
      enc_n  = 3'd1;
      enc[0] = cp[7:0];
    end else if (cp <= CP2_MAX) begin
      enc_n  = 3'd2;
      enc[0] = LEAD2 | {3'b000, cp[10:6]};
      enc[1] = cont_byte(cp[5:0]);
    end else if (cp <= CP3_MAX) begin
      enc_n  = 3'd3;
      enc[0] = LEAD3 | {4'b0000, cp[15:12]};
      enc[1] = cont_byte(cp[11:6]);
      enc[2] = cont_byte(cp[5:0]);
    end else begin
      enc_n  = 3'd4;
      enc[0] = LEAD4 + {4'b0000, cp[21:18]};
      enc[1] = cont_byte(cp[17:12]);
      enc[2] = cont_byte(cp[11:6]);
      enc[3] = cont_byte(cp[5:0]);
    end
    if (!head_job.cp_valid) begin
      enc_n = '0;
    end
  end

  // request register: load from queue, shift out one byte per emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      rem_r       <= '0;
      term_r      <= 1'b0;
      odd_r       <= 1'b0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      rem_r       <= enc_n;
      term_r      <= head_job.term;
      odd_r       <= head_job.odd;
      bytes_r     <= enc;
    end else if (done) begin
      cur_valid_r <= 1'b0;
    end else if (emit && rem_r != '0) begin
      rem_r      <= rem_r - 1'b1;
      bytes_r[0] <= bytes_r[1];
      bytes_r[1] <= bytes_r[2];
      bytes_r[2] <= bytes_r[3];
      bytes_r[3] <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= cur_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r     <= e_byte;
      run_last_r <= e_last;
      is_term_r  <= e_term;
      odd_out_r  <= e_odd;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = byte_r;
  assign out_run_last      = run_last_r;
  assign out_is_terminator = is_term_r;
  assign out_odd_dropped   = odd_out_r;

endmodule

/* rtl/core/utf16le_to_utf8_stream.sv */
`timescale 1ns / 1ps
// UTF-16LE to UTF-8 stream converter.
// Input channel (in_valid/in_ready): one byte of UTF-16LE text per request,
// low byte of each unit first; in_string_last marks the final byte.
// Output channel (out_valid/out_ready): one UTF-8 byte per request.
// out_run_last flags the last byte caused by one input byte, and the string
// closes with a zero byte with out_is_terminator set; out_odd_dropped on it
// reports a dropped trailing odd byte. Surrogate pairs merge into one code
// point; a surrogate still parked at string end goes out as three bytes.
// The first byte of a result passes the queue slot, the request register and
// the output register. The serializer sends one byte per cycle while the
// receiver is ready, so a code point yields 1 to 4 output bytes. Input bytes
// are taken one per cycle until the request queue (QDEPTH entries) is full.
// Reset clears the pairing state, the queue and the output register.
// When the receiver stalls the output byte holds, the serializer waits and
// the queue fills; in_ready drops only once the queue is full.
module utf16le_to_utf8_stream
  import u16u8_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_string_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_is_terminator,
  output logic       out_odd_dropped
);

  logic acc, push, full, pop, head_valid;
  job_t push_job, head_job;

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  // byte pairing and surrogate handling
  u16u8_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .in_byte        (in_byte),
    .in_string_last (in_string_last),
    .push           (push),
    .job            (push_job)
  );

  // request queue
  u16u8_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // utf-8 serializer
  u16u8_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_job          (head_job),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_is_terminator (out_is_terminator),
    .out_odd_dropped   (out_odd_dropped)
  );

endmodule

/* bench/utf16le_to_utf8_stream_tb.sv */
`timescale 1ns / 1ps

module utf16le_to_utf8_stream_tb;

  localparam int TARGET_BYTES = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_SHOWN = 10;

  localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HI_SURR_END   = 16'hDBFF;
  localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
  localparam logic [15:0] LO_SURR_END   = 16'hDFFF;
  localparam logic [21:0] PLANE1_BASE   = 22'h010000;
  localparam logic [21:0] ONE_BYTE_MAX  = 22'h00007F;
  localparam logic [21:0] TWO_BYTE_MAX  = 22'h0007FF;
  localparam logic [21:0] THREE_BYTE_MAX = 22'h00FFFF;

  // kinds of unit that random strings are built from
  typedef enum int {
    K_ASCII, K_TWO, K_THREE, K_PAIR, K_PAIR2, K_BROKEN, K_UPPER, K_ANY, K_LONE
  } unit_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       term;
    logic       odd;
  } utf8_byte_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         gap;
    bit         drain;
  } text_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_string_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_is_terminator;
  logic       out_odd_dropped;

  utf16le_to_utf8_stream dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_string_last   (in_string_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_is_terminator(out_is_terminator),
    .out_odd_dropped  (out_odd_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_byte_t text_q[$];
  utf8_byte_t utf8_q[$];

  // transcoder state mirror
  logic [7:0]  held_lo;
  logic        lo_held;
  logic [10:0] pend_bits;
  logic        pend_held;

  bit calm_string;
  bit drain_mark;
  int idle_cnt;
  int stall_left;
  int n_strings, n_in, n_out, n_term, n_odd, n_errors;

  // expected utf-8 bytes for one code point
  function automatic void encode_cp(input logic [21:0] cp, ref utf8_byte_t step_q[$]);
    if (cp <= ONE_BYTE_MAX) begin
      step_q.push_back('{cp[7:0], 1'b0, 1'b0, 1'b0});
    end else if (cp <= TWO_BYTE_MAX) begin
      step_q.push_back('{8'hC0 + 8'(cp >> 6), 1'b0, 1'b0, 1'b0});
      step_q.push_back('{8'h80 + {2'b00, cp[5:0]}, 1'b0, 1'b0, 1'b0});
    end else if (cp <= THREE_BYTE_MAX) begin
      step_q.push_back('{8'hE0 + 8'(cp >> 12), 1'b0, 1'b0, 1'b0});
      step_q.push_back('{8'h80 + {2'b00, cp[11:6]}, 1'b0, 1'b0, 1'b0});
      step_q.push_back('{8'h80 + {2'b00, cp[5:0]}, 1'b0, 1'b0, 1'b0});
    end else begin
      step_q.push_back('{8'hF0 + 8'(cp >> 18), 1'b0, 1'b0, 1'b0});
      step_q.push_back('{8'h80 + {2'b00, cp[17:12]}, 1'b0, 1'b0, 1'b0});
      step_q.push_back('{8'h80 + {2'b00, cp[11:6]}, 1'b0, 1'b0, 1'b0});
      step_q.push_back('{8'h80 + {2'b00, cp[5:0]}, 1'b0, 1'b0, 1'b0});
    end
  endfunction

  // advance the mirror by one input byte and queue what it yields
  function automatic void transcode_byte(input logic [7:0] data, input logic last);
    utf8_byte_t step_q[$];
    logic [15:0] unit;
    logic [21:0] cp;
    logic odd;
    if (!lo_held) begin
      held_lo = data;
      lo_held = 1'b1;
    end else begin
      unit = {data, held_lo};
      lo_held = 1'b0;
      held_lo = 8'h00;
      if (pend_held) begin
        cp = ({11'b0, pend_bits} << 10) + PLANE1_BASE + {12'b0, unit[9:0]};
        pend_held = 1'b0;
        pend_bits = '0;
        encode_cp(cp, step_q);
      end else if (unit >= HI_SURR_FIRST && unit <= LO_SURR_END && !last) begin
        pend_bits = 11'(unit - HI_SURR_FIRST);
        pend_held = 1'b1;
      end else begin
        encode_cp({6'b0, unit}, step_q);
      end
    end
    if (last) begin
      odd = lo_held;
      if (pend_held) encode_cp({6'b0, HI_SURR_FIRST} + {11'b0, pend_bits}, step_q);
      step_q.push_back('{8'h00, 1'b0, 1'b1, odd});
      held_lo = 8'h00;
      lo_held = 1'b0;
      pend_bits = '0;
      pend_held = 1'b0;
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].run_last = 1'b1;
    foreach (step_q[i]) utf8_q.push_back(step_q[i]);
  endfunction

  task automatic add_byte(input logic [7:0] data, input logic last);
    text_byte_t it;
    it.data = data;
    it.last = last;
    it.gap = calm_string ? 0 : $urandom_range(0, 3);
    it.drain = drain_mark;
    drain_mark = 1'b0;
    text_q.push_back(it);
    if (last) n_strings++;
  endtask

  task automatic add_unit(input logic [15:0] u, input logic last);
    add_byte(u[7:0], 1'b0);
    add_byte(u[15:8], last);
  endtask

  task automatic add_random_string();
    int n;
    bit odd_tail;
    unit_kind_t kind;
    logic [15:0] u;
    n = $urandom_range(1, 6);
    odd_tail = ($urandom_range(0, 4) == 0);
    calm_string = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      kind = unit_kind_t'($urandom_range(0, int'(K_LONE)));
      case (kind)
        K_ASCII: u = 16'($urandom_range(0, 16'h007F));
        K_TWO:   u = 16'($urandom_range(16'h0080, 16'h07FF));
        K_THREE: u = 16'($urandom_range(16'h0800, 16'hD7FF));
        K_PAIR, K_PAIR2: begin
          add_unit(16'($urandom_range(HI_SURR_FIRST, HI_SURR_END)), 1'b0);
          u = 16'($urandom_range(LO_SURR_FIRST, LO_SURR_END));
        end
        K_BROKEN: begin
          add_unit(16'($urandom_range(HI_SURR_FIRST, LO_SURR_END)), 1'b0);
          u = 16'($urandom);
        end
        K_UPPER: u = 16'($urandom_range(16'hE000, 16'hFFFF));
        K_LONE:  u = 16'($urandom_range(HI_SURR_FIRST, LO_SURR_END));
        default: u = 16'($urandom);
      endcase
      add_unit(u, (i == n - 1) && !odd_tail);
    end
    if (odd_tail) add_byte(8'($urandom), 1'b1);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_cnt = 0;
    end else if (!in_valid || in_ready) begin
      if (text_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_cnt < text_q[0].gap ||
                   (text_q[0].drain && ((in_valid && in_ready) || utf8_q.size() != 0))) begin
        idle_cnt++;
        in_valid <= 1'b0;
      end else begin
        in_byte <= text_q[0].data;
        in_string_last <= text_q[0].last;
        in_valid <= 1'b1;
        void'(text_q.pop_front());
        idle_cnt = 0;
      end
    end
  end

  // monitor: predict on accepted input, check accepted output
  always @(posedge clk) begin
    utf8_byte_t want;
    utf8_byte_t got;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      held_lo = 8'h00;
      lo_held = 1'b0;
      pend_bits = '0;
      pend_held = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        n_in++;
        transcode_byte(in_byte, in_string_last);
      end
      if (out_valid && out_ready) begin
        n_out++;
        got = '{out_byte, out_run_last, out_is_terminator, out_odd_dropped};
        if (got.term) n_term++;
        if (got.term && got.odd) n_odd++;
        if (utf8_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("%0t: unexpected byte %h run_last %b term %b odd %b", $realtime,
                     got.data, got.run_last, got.term, got.odd);
        end else begin
          want = utf8_q.pop_front();
          if (got.data !== want.data || got.run_last !== want.run_last ||
              got.term !== want.term || got.odd !== want.odd) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN)
              $display("%0t: exp byte %h rl %b term %b odd %b, got %h rl %b term %b odd %b",
                       $realtime, want.data, want.run_last, want.term, want.odd,
                       got.data, got.run_last, got.term, got.odd);
          end
        end
        // quiet stretches with the receiver always ready
        stall_left = ((n_out / 64) % 3 == 0) ? 0 : $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int str_idx;
    // directed: utf-8 length boundaries
    calm_string = 1'b0;
    drain_mark = 1'b0;
    add_unit(16'h007F, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(16'h07FF, 1'b0);
    add_unit(16'h0800, 1'b0);
    add_unit(16'hFFFF, 1'b1);
    // proper pair, then a high surrogate with a non-surrogate partner
    calm_string = 1'b1;
    add_unit(16'hD83D, 1'b0);
    add_unit(16'hDE00, 1'b0);
    add_unit(16'hDBFF, 1'b0);
    add_unit(16'h0041, 1'b1);
    // low surrogate first: code point beyond the unicode range
    calm_string = 1'b0;
    add_unit(16'hDFFF, 1'b0);
    add_unit(16'hFFFF, 1'b1);
    // surrogate still parked when an odd last byte arrives
    add_unit(16'hD800, 1'b0);
    add_byte(8'hA5, 1'b1);
    // lone odd byte string
    add_byte(8'h5A, 1'b1);
    // surrogate completed by the final byte is sent as is
    add_unit(16'hDABC, 1'b1);

    // random strings, with a full drain before two of them
    str_idx = 0;
    while (text_q.size() < TARGET_BYTES) begin
      drain_mark = (str_idx == 0 || str_idx == 30);
      add_random_string();
      str_idx++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || in_valid) @(posedge clk);
    while (utf8_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d strings, %0d utf-16 bytes in, %0d utf-8 bytes out", n_strings,
             n_in, n_out);
    $display("%0d terminators, %0d with a dropped odd byte, %0d mismatches", n_term, n_odd,
             n_errors);
    if (n_errors == 0 && utf8_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
